/* hdl/ivn_pkg.sv */
package ivn_pkg;

    // Element and result widths
    localparam int ELEM_W = 32;
    localparam int NORM_W = ELEM_W - 1;
    localparam int SQ_W   = 2 * ELEM_W;
    localparam int ACC_W  = 128;
    // Radicand that can still give an in-range root
    localparam int RAD_W  = 2 * NORM_W;
    // Partial remainder of the digit-by-digit root
    localparam int REM_W  = NORM_W + 3;
    // Root step counter, counts 0 .. NORM_W
    localparam int CNT_W  = $clog2(NORM_W + 1);

    typedef struct packed {
        logic signed [ELEM_W-1:0] element;
        logic                     has_element;
        logic                     last;
    } t_in_beat;

    typedef struct packed {
        logic [NORM_W-1:0] norm;
        logic              saturated;
    } t_out_beat;

    // Controller to datapath
    typedef struct packed {
        logic load_in;
        logic square;
        logic accum;
        logic prep;
        logic step;
        logic emit;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic last;
        logic root_done;
    } t_sts;

endpackage

/* hdl/ivn_dp.sv */
module ivn_dp import ivn_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_beat  i_in_data,
    input  t_cmd      i_cmd,
    output t_sts      o_sts,
    output t_out_beat o_out_data
);

    logic [ELEM_W-1:0] r_mag;
    logic              r_has;
    logic              r_last;
    logic [SQ_W-1:0]   r_sq;
    logic [ACC_W-1:0]  r_acc;
    logic [ACC_W-1:0]  n_acc;
    logic [RAD_W-1:0]  r_rad;
    logic [REM_W-1:0]  r_rem;
    logic [NORM_W-1:0] r_root;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_sat;
    t_out_beat         r_out;

    logic [ELEM_W-1:0] mag_in;
    logic [ACC_W:0]    acc_sum;
    logic [REM_W-1:0]  rem_shift;
    logic [REM_W-1:0]  trial;
    logic              take;

    // Magnitude of the incoming element
    assign mag_in = i_in_data.element[ELEM_W-1] ? (~i_in_data.element + ELEM_W'(1))
                                                 : i_in_data.element;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_mag  <= mag_in;
            r_has  <= i_in_data.has_element;
            r_last <= i_in_data.last;
        end
    end

    // Square, registered before the add
    always_ff @(posedge i_clk) begin
        if (i_cmd.square) begin
            r_sq <= r_has ? (SQ_W'(r_mag) * SQ_W'(r_mag)) : '0;
        end
    end

    // Saturating accumulator
    assign acc_sum = {1'b0, r_acc} + (ACC_W + 1)'(r_sq);

    always_comb begin
        n_acc = r_acc;
        if (i_cmd.prep) begin
            n_acc = '0;
        end else if (i_cmd.accum) begin
            n_acc = acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else begin
            r_acc <= n_acc;
        end
    end

    // Digit-by-digit root, one result bit per step
    assign rem_shift = {r_rem[REM_W-3:0], r_rad[RAD_W-1 -: 2]};
    assign trial     = REM_W'({r_root, 2'b01});
    assign take      = (rem_shift >= trial);

    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_rad  <= r_acc[RAD_W-1:0];
            r_sat  <= |r_acc[ACC_W-1:RAD_W];
            r_rem  <= '0;
            r_root <= '0;
            r_cnt  <= '0;
        end else if (i_cmd.step) begin
            r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
            r_rem  <= take ? (rem_shift - trial) : rem_shift;
            r_root <= {r_root[NORM_W-2:0], take};
            r_cnt  <= r_cnt + CNT_W'(1);
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.norm      <= r_sat ? '1 : r_root;
            r_out.saturated <= r_sat;
        end
    end

    assign o_sts.last      = r_last;
    assign o_sts.root_done = (r_cnt == CNT_W'(NORM_W));
    assign o_out_data      = r_out;

endmodule

/* hdl/ivn_ctrl.sv */
module ivn_ctrl import ivn_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    output logic o_out_valid,
    input  logic i_out_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SQUARE = 5'b00010,
        S_ACCUM  = 5'b00100,
        S_ROOT   = 5'b01000,
        S_DONE   = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   out_free;
    logic   in_take;

    assign out_free = !r_out_valid || !i_out_stall;
    assign in_take  = i_in_valid && (r_state == S_IDLE);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load_in = in_take;
                if (in_take) begin
                    n_state = S_SQUARE;
                end
            end
            S_SQUARE: begin
                o_cmd.square = 1'b1;
                n_state      = S_ACCUM;
            end
            S_ACCUM: begin
                o_cmd.accum = 1'b1;
                n_state     = i_sts.last ? S_ROOT : S_IDLE;
            end
            S_ROOT: begin
                // this state loads the radicand from the accumulator
                o_cmd.prep = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (!i_sts.root_done) begin
                    o_cmd.step = 1'b1;
                end else if (out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Result beat valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    // A new result never overwrites one still waiting
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> out_free)
        else $error("result emitted over a stalled beat");

    // An accepted beat always goes through square and accumulate
    a_accept_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> (r_state == S_SQUARE) ##1 (r_state == S_ACCUM))
        else $error("accepted beat skipped the datapath");

    // Root stepping never overlaps the radicand load, the output load or an accumulate
    a_step_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.step && (o_cmd.prep || o_cmd.emit || o_cmd.accum)))
        else $error("conflicting datapath commands");

    // The root load clears the root counter, so root_done drops after it
    a_root_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.prep |=> !i_sts.root_done)
        else $error("root counter not cleared on load");

endmodule

/* hdl/integer_vector_euclidean_norm_unit.sv */
// Streams signed 32-bit vector elements and returns, on the beat marked last, the floor square
// root of the exact sum of squares (31 bits, saturated to 2^31-1 with the saturated flag set).
// A beat with has_element low and last high closes a vector; with nothing summed it gives 0.
// Each input beat passes through load, 32x32 square and 128-bit saturating add. A last beat
// then adds the radicand load, the bit-serial root and the output load, so the
// shared root unit sets the cost of ending a vector. The result sits in an output register,
// and the next vector's beats are taken while it waits; a second result waits for that
// register to drain.
module integer_vector_euclidean_norm_unit import ivn_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_beat  i_in_data,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_beat o_out_data,
    input  logic      i_out_stall
);

    t_cmd cmd;
    t_sts sts;

    ivn_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    ivn_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_out_data (o_out_data)
    );

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
    import ivn_pkg::*;

    localparam logic signed [ELEM_W-1:0] ELEM_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
    localparam logic signed [ELEM_W-1:0] ELEM_MIN = {1'b1, {(ELEM_W-1){1'b0}}};
    localparam logic [NORM_W-1:0]        NORM_MAX = {NORM_W{1'b1}};
    localparam int TOTAL_ITEMS   = 1550;
    localparam int DRAIN_CYCLES  = 40;
    localparam int LONG_HOLD     = 400;
    localparam int HOLD_AT_NORM  = 120;
    localparam int PAUSE_AT_ITEM = 800;

    // Tracks the running sum of squares and the norms still owed by the block
    class norm_scoreboard;
        logic [ACC_W-1:0] square_sum;
        t_out_beat        expected_norms[$];
        int               errors;

        function new();
            square_sum = '0;
            errors     = 0;
        endfunction

        // Accepted input beat: accumulate and, on last, queue the expected norm
        function void note_beat(t_in_beat b);
            logic [ELEM_W-1:0] mag;
            logic [SQ_W-1:0]   sq;
            logic [ACC_W:0]    total;
            logic [NORM_W-1:0] root;
            logic [NORM_W-1:0] cand;
            logic [ACC_W-1:0]  cand_w;
            t_out_beat         res;
            if (b.has_element) begin
                // two's complement magnitude; the minimum maps to 2^(W-1) unsigned
                mag   = b.element[ELEM_W-1] ? ELEM_W'(-b.element) : ELEM_W'(b.element);
                sq    = SQ_W'(mag) * SQ_W'(mag);
                total = {1'b0, square_sum} + (ACC_W+1)'(sq);
                square_sum = total[ACC_W] ? {ACC_W{1'b1}} : total[ACC_W-1:0];
            end
            if (b.last) begin
                if ((square_sum >> (2*ELEM_W-2)) != 0) begin
                    res.norm      = NORM_MAX;
                    res.saturated = 1'b1;
                end else begin
                    // bit-serial floor root, MSB first
                    root = '0;
                    for (int i = NORM_W-1; i >= 0; i--) begin
                        cand   = root | (NORM_W'(1) << i);
                        cand_w = ACC_W'(cand);
                        if (cand_w * cand_w <= square_sum) root = cand;
                    end
                    res.norm      = root;
                    res.saturated = 1'b0;
                end
                expected_norms.push_back(res);
                square_sum = '0;
            end
        endfunction

        // Accepted output beat: compare with the oldest expected norm
        function void check_result(t_out_beat r);
            t_out_beat exp_r;
            if (expected_norms.size() == 0) begin
                $error("unexpected result beat: norm %0d saturated %0b", r.norm, r.saturated);
                errors++;
                return;
            end
            exp_r = expected_norms.pop_front();
            if (r.norm !== exp_r.norm) begin
                $error("norm mismatch: expected %0d, actual %0d", exp_r.norm, r.norm);
                errors++;
            end
            if (r.saturated !== exp_r.saturated) begin
                $error("saturated mismatch: expected %0b, actual %0b",
                       exp_r.saturated, r.saturated);
                errors++;
            end
        endfunction

        function int pending();
            return expected_norms.size();
        endfunction
    endclass

    logic      i_clk     = 1'b0;
    logic      i_rst_n   = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_beat  in_beat   = '0;
    logic      out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_beat o_out_data;

    norm_scoreboard norms = new();
    int  items_sent = 0;
    bit  no_idle    = 1'b0;

    always #5 i_clk = ~i_clk;

    integer_vector_euclidean_norm_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_beat),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (out_stall)
    );

    function automatic t_in_beat make_beat(logic signed [ELEM_W-1:0] el, logic has, logic lst);
        t_in_beat b;
        b.element     = el;
        b.has_element = has;
        b.last        = lst;
        return b;
    endfunction

    // Element value drawn from a mix of small, mid, near-full-scale and extreme magnitudes
    function automatic logic signed [ELEM_W-1:0] pick_element();
        logic signed [ELEM_W-1:0] v;
        case ($urandom_range(0, 4))
            0: v = $signed($urandom_range(0, 32)) - 16;
            1: v = $urandom;
            2: begin
                v = $urandom_range(0, 65535);
                if ($urandom_range(0, 1)) v = -v;
            end
            3: begin
                case ($urandom_range(0, 3))
                    0: v = ELEM_MAX;
                    1: v = ELEM_MIN;
                    2: v = ELEM_MAX - $urandom_range(0, 7);
                    default: v = ELEM_MIN + $urandom_range(0, 7);
                endcase
            end
            default: begin
                v = $urandom_range(32'h4000_0000, 32'h7fff_ffff);
                if ($urandom_range(0, 1)) v = -v;
            end
        endcase
        return v;
    endfunction

    // Offer one beat after a random gap and hold it until it is taken
    task automatic send_beat(t_in_beat b);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_beat  <= b;
        do @(posedge i_clk); while (o_in_stall);
        norms.note_beat(b);
        items_sent++;
    endtask

    // One vector of random length; sometimes closed by a separate element-less beat
    task automatic send_vector();
        int len;
        bit close_apart;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 5);
        close_apart = (len == 0) || ($urandom_range(0, 5) == 0);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 9) == 0) send_beat(make_beat($urandom, 1'b0, 1'b0));
            send_beat(make_beat(pick_element(), 1'b1, !close_apart && (i == len-1)));
        end
        if (close_apart) send_beat(make_beat($urandom, 1'b0, 1'b1));
    endtask

    // Output side: random stall per beat plus one long hold-off
    initial begin : receiver
        int gap;
        int taken;
        taken = 0;
        @(posedge i_rst_n);
        forever begin
            gap = no_idle ? 0 : $urandom_range(0, 5);
            if (taken == HOLD_AT_NORM) gap = LONG_HOLD;
            if (gap > 0) begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
                out_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!o_out_valid);
            taken++;
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !out_stall) norms.check_result(o_out_data);
    end

    initial begin : watchdog
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    initial begin : stimulus
        bit paused;
        paused = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty vector, ignored beat, zero and unit elements
        send_beat(make_beat('0, 1'b0, 1'b1));
        send_beat(make_beat(ELEM_MIN, 1'b0, 1'b0));
        send_beat(make_beat(ELEM_MAX, 1'b0, 1'b1));
        send_beat(make_beat('0, 1'b1, 1'b1));
        send_beat(make_beat(1, 1'b1, 1'b1));
        send_beat(make_beat(-1, 1'b1, 1'b1));
        // 3-4-5 and a non-square sum
        send_beat(make_beat(3, 1'b1, 1'b0));
        send_beat(make_beat(-4, 1'b1, 1'b1));
        send_beat(make_beat(3, 1'b1, 1'b0));
        send_beat(make_beat(-3, 1'b1, 1'b1));
        // full-scale positive fits, most negative saturates
        send_beat(make_beat(ELEM_MAX, 1'b1, 1'b1));
        send_beat(make_beat(ELEM_MIN, 1'b1, 1'b1));
        // full-scale element plus one still fits
        send_beat(make_beat(ELEM_MAX, 1'b1, 1'b0));
        send_beat(make_beat(1, 1'b1, 1'b1));
        // two full-scale elements saturate
        send_beat(make_beat(ELEM_MAX, 1'b1, 1'b0));
        send_beat(make_beat(ELEM_MAX, 1'b1, 1'b1));
        // vector closed by an element-less beat, with and without saturation
        send_beat(make_beat(ELEM_MIN, 1'b1, 1'b0));
        send_beat(make_beat(ELEM_MAX, 1'b0, 1'b1));
        send_beat(make_beat(5, 1'b1, 1'b0));
        send_beat(make_beat(ELEM_MIN, 1'b0, 1'b0));
        send_beat(make_beat(-1, 1'b0, 1'b1));
        send_beat(make_beat(ELEM_MIN + 1, 1'b1, 1'b1));

        // random vectors; two bursts without idling, one pause to drain
        while (items_sent < TOTAL_ITEMS) begin
            no_idle = (items_sent >= 300 && items_sent < 450) ||
                      (items_sent >= 1100 && items_sent < 1200);
            if (!paused && items_sent >= PAUSE_AT_ITEM) begin
                paused = 1'b1;
                in_valid <= 1'b0;
                do @(posedge i_clk); while (norms.pending() != 0);
            end
            send_vector();
        end
        no_idle = 1'b0;
        in_valid <= 1'b0;

        while (norms.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (norms.errors == 0 && norms.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
